/* design/mtp_pkg.sv */
package mtp_pkg;

  typedef enum logic [2:0] {
    CFG_TWIST_COEF = 3'd0,
    CFG_MASK_B     = 3'd1,
    CFG_MASK_C     = 3'd2,
    CFG_MASK_D     = 3'd3,
    CFG_SHIFT_U    = 3'd4,
    CFG_SHIFT_S    = 3'd5,
    CFG_SHIFT_T    = 3'd6,
    CFG_SHIFT_L    = 3'd7
  } cfg_reg_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INIT     = 7'b0000010,
    S_SEED     = 7'b0000100,
    S_READ_MID = 7'b0001000,
    S_TWIST    = 7'b0010000,
    S_TEMPER_A = 7'b0100000,
    S_TEMPER_B = 7'b1000000
  } state_t;

  localparam logic [31:0] TWIST_COEF_RST = 32'h9908_B0DF;
  localparam logic [31:0] MASK_B_RST     = 32'h9D2C_5680;
  localparam logic [31:0] MASK_C_RST     = 32'hEFC6_0000;
  localparam logic [31:0] MASK_D_RST     = 32'hFFFF_FFFF;
  localparam logic [4:0]  SHIFT_U_RST    = 5'd11;
  localparam logic [4:0]  SHIFT_S_RST    = 5'd7;
  localparam logic [4:0]  SHIFT_T_RST    = 5'd15;
  localparam logic [4:0]  SHIFT_L_RST    = 5'd18;

  localparam int SEED_SHIFT = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_W     = 32;

endpackage

/* design/mersenne_twister_prng.sv */
// mt19937-style generator with the state words held in a dual-read-port ram
// input channel (in_valid/in_ready): action 0 requests one word, action 1
// reseeds the store from seed_value; a reseed gives no output request
// output channel (out_valid/out_ready): one tempered 32-bit word per extract
// an extract is accepted in idle and steps through READ_MID, TWIST,
// TEMPER_A and TEMPER_B; its word is loaded into the output register and
// out_valid rises as it leaves TEMPER_B; the next extract is accepted only
// back in idle, after three ram reads (word, its neighbor, the middle word)
// over two read ports, a write-back in TWIST and tempering in TEMPER_A/B
// a reseed keeps in_ready low while the seed recurrence writes one word
// per cycle through the single write port
// reset (rst, synchronous) loads the default registers and runs the same
// seeding pass from DEFAULT_SEED before in_ready rises
// while out_ready is low a finished word waits in the output register; a new
// request is still accepted, and an extract holds in its last tempering
// cycle until the output register is free
// config writes (cfg_wr_en, cfg_addr, cfg_data) are taken in any cycle
module mersenne_twister_prng #(
  parameter int unsigned STATE_WORDS     = 624,
  parameter int unsigned MIDDLE_OFFSET   = 397,
  parameter int unsigned LOWER_BITS      = 31,
  parameter logic [31:0] INIT_MULTIPLIER = 32'd1812433253,
  parameter logic [31:0] DEFAULT_SEED    = 32'd5489
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [31:0]                    seed_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    random_word,
  input  logic                           cfg_wr_en,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mtp_pkg::WORD_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam int CNT_W = $clog2(STATE_WORDS + 1);
  localparam int MID_OFF = MIDDLE_OFFSET % STATE_WORDS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [CNT_W-1:0] END_IDX = CNT_W'(STATE_WORDS);
  localparam logic [31:0] LOW_MASK = (32'h1 << LOWER_BITS) - 32'h1;
  localparam logic [31:0] HIGH_MASK = ~LOW_MASK;

  mtp_pkg::state_t state;

  logic [31:0] twist_coef, mask_b, mask_c, mask_d;
  logic [4:0]  shift_u, shift_s, shift_t, shift_l;

  logic [31:0] state_mem [STATE_WORDS];
  logic [31:0] rd_a, rd_b;
  logic [IDX_W-1:0] addr_a, addr_b, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [CNT_W-1:0] read_index;
  logic [IDX_W-1:0] cur_idx, seed_cnt, idx_sel, idx_sel_next, mid_idx;
  logic [IDX_W:0]   mid_sum;
  logic [31:0] seed_reg, prev, seed_word;
  logic [31:0] word_cur, word_next, temp;
  logic [31:0] x_word, y_word, t1, t2, t3, t4;
  logic        in_fire;
  logic        load_out;

  assign in_ready = (state == mtp_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_out = (state == mtp_pkg::S_TEMPER_B) && (!out_valid || out_ready);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      twist_coef <= mtp_pkg::TWIST_COEF_RST;
      mask_b     <= mtp_pkg::MASK_B_RST;
      mask_c     <= mtp_pkg::MASK_C_RST;
      mask_d     <= mtp_pkg::MASK_D_RST;
      shift_u    <= mtp_pkg::SHIFT_U_RST;
      shift_s    <= mtp_pkg::SHIFT_S_RST;
      shift_t    <= mtp_pkg::SHIFT_T_RST;
      shift_l    <= mtp_pkg::SHIFT_L_RST;
    end else if (cfg_wr_en) begin
      unique case (mtp_pkg::cfg_reg_t'(cfg_addr))
        mtp_pkg::CFG_TWIST_COEF: twist_coef <= cfg_data;
        mtp_pkg::CFG_MASK_B:     mask_b     <= cfg_data;
        mtp_pkg::CFG_MASK_C:     mask_c     <= cfg_data;
        mtp_pkg::CFG_MASK_D:     mask_d     <= cfg_data;
        mtp_pkg::CFG_SHIFT_U:    shift_u    <= cfg_data[4:0];
        mtp_pkg::CFG_SHIFT_S:    shift_s    <= cfg_data[4:0];
        mtp_pkg::CFG_SHIFT_T:    shift_t    <= cfg_data[4:0];
        mtp_pkg::CFG_SHIFT_L:    shift_l    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // index arithmetic
  always_comb begin
    idx_sel      = (read_index >= END_IDX) ? '0 : read_index[IDX_W-1:0];
    idx_sel_next = (idx_sel == LAST_IDX) ? '0 : idx_sel + IDX_W'(1);
    mid_sum      = {1'b0, cur_idx} + (IDX_W + 1)'(MID_OFF);
    mid_idx      = (mid_sum >= (IDX_W + 1)'(STATE_WORDS))
                 ? IDX_W'(mid_sum - (IDX_W + 1)'(STATE_WORDS))
                 : mid_sum[IDX_W-1:0];
  end

  // seed recurrence
  assign seed_word = INIT_MULTIPLIER * (prev ^ (prev >> mtp_pkg::SEED_SHIFT))
                   + 32'(seed_cnt);

  // twist and tempering
  always_comb begin
    x_word = (word_cur & HIGH_MASK) | (word_next & LOW_MASK);
    y_word = rd_b ^ (x_word >> 1) ^ (x_word[0] ? twist_coef : 32'h0);
    t1 = temp ^ ((temp >> shift_u) & mask_d);
    t2 = t1 ^ ((t1 << shift_s) & mask_b);
    t3 = temp ^ ((temp << shift_t) & mask_c);
    t4 = t3 ^ (t3 >> shift_l);
  end

  // ram port control
  always_comb begin
    addr_a  = cur_idx;
    addr_b  = mid_idx;
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = y_word;
    unique case (state)
      mtp_pkg::S_IDLE: begin
        addr_a = idx_sel;
        addr_b = idx_sel_next;
      end
      mtp_pkg::S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = seed_reg;
      end
      mtp_pkg::S_SEED: begin
        wr_en   = 1'b1;
        wr_addr = seed_cnt;
        wr_data = seed_word;
      end
      mtp_pkg::S_TWIST: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) state_mem[wr_addr] <= wr_data;
    rd_a <= state_mem[addr_a];
    rd_b <= state_mem[addr_b];
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtp_pkg::S_INIT;
      seed_reg   <= DEFAULT_SEED;
      read_index <= END_IDX;
      seed_cnt   <= '0;
    end else begin
      unique case (state)
        mtp_pkg::S_IDLE: begin
          if (in_fire) begin
            if (action) begin
              seed_reg <= seed_value;
              state    <= mtp_pkg::S_INIT;
            end else begin
              cur_idx <= idx_sel;
              state   <= mtp_pkg::S_READ_MID;
            end
          end
        end
        mtp_pkg::S_INIT: begin
          prev     <= seed_reg;
          seed_cnt <= IDX_W'(1);
          state    <= mtp_pkg::S_SEED;
        end
        mtp_pkg::S_SEED: begin
          prev     <= seed_word;
          seed_cnt <= seed_cnt + IDX_W'(1);
          if (seed_cnt == LAST_IDX) begin
            read_index <= END_IDX;
            state      <= mtp_pkg::S_IDLE;
          end
        end
        mtp_pkg::S_READ_MID: begin
          word_cur  <= rd_a;
          word_next <= rd_b;
          state     <= mtp_pkg::S_TWIST;
        end
        mtp_pkg::S_TWIST: begin
          temp       <= y_word;
          read_index <= CNT_W'(cur_idx) + CNT_W'(1);
          state      <= mtp_pkg::S_TEMPER_A;
        end
        mtp_pkg::S_TEMPER_A: begin
          temp  <= t2;
          state <= mtp_pkg::S_TEMPER_B;
        end
        mtp_pkg::S_TEMPER_B: begin
          if (load_out) begin
            random_word <= t4;
            state       <= mtp_pkg::S_IDLE;
          end
        end
        default: state <= mtp_pkg::S_IDLE;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == mtp_pkg::S_TEMPER_B && out_valid && !out_ready)
      |=> (state == mtp_pkg::S_TEMPER_B && $stable(random_word)))
    else $error("pending output word overwritten");

  a_seed_done: assert property (@(posedge clk) disable iff (rst)
    (state == mtp_pkg::S_SEED && seed_cnt == LAST_IDX)
      |=> (state == mtp_pkg::S_IDLE && read_index == END_IDX))
    else $error("seeding pass did not end at the last word");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == mtp_pkg::S_READ_MID || state == mtp_pkg::S_TWIST)
      |-> (32'(cur_idx) < STATE_WORDS && 32'(mid_idx) < STATE_WORDS))
    else $error("ram index out of range");

  a_extract_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !action) |=> (state == mtp_pkg::S_READ_MID && !in_ready))
    else $error("extract request did not start the read sequence");

endmodule
